FILE: hw/rtl/sct_pkg.sv
package sct_pkg;

    // Fraction bits of the internal unsigned magnitudes
    localparam int FRAC_BITS = 30;

    // Working width of the angle during range reduction (Q7.24 shifted up)
    localparam int X_W = 32 + FRAC_BITS - 24;

    // pi * 2^62, then pi, two pi and pi/2 in FRAC_BITS with round half up
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_F      = ((PI_Q62 >> (62 - FRAC_BITS - 1)) + 64'd1) >> 1;
    localparam logic [63:0] TWO_PI_F  = ((PI_Q62 >> (61 - FRAC_BITS - 1)) + 64'd1) >> 1;
    localparam logic [63:0] HALF_PI_F = ((PI_Q62 >> (63 - FRAC_BITS - 1)) + 64'd1) >> 1;
    localparam logic [63:0] ONE_F     = 64'd1 << FRAC_BITS;

    localparam logic [X_W-1:0] PI_X      = PI_F[X_W-1:0];
    localparam logic [X_W-1:0] TWO_PI_X  = TWO_PI_F[X_W-1:0];
    localparam logic [X_W-1:0] HALF_PI_X = HALF_PI_F[X_W-1:0];
    localparam logic [X_W-1:0] ONE_X     = ONE_F[X_W-1:0];

    // Restoring reduction by two pi: one shifted subtract per cycle
    localparam int TWO_PI_W  = $clog2(TWO_PI_F);
    localparam int RED_STEPS = X_W - TWO_PI_W;
    localparam int RED_W     = $clog2(RED_STEPS);

    // Saturation limit of the Q2.30 result
    localparam logic [33:0] SAT_ONE = 34'h0_4000_0000;

    // Register word index on the configuration port
    localparam logic REG_TOLERANCE = 1'b0;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_REDUCE,
        OP_FOLD_PI,
        OP_FOLD_HALF,
        OP_SQUARE,
        OP_SEED,
        OP_MUL_TERM,
        OP_MUL_REC,
        OP_MUL_DEN,
        OP_CORR
    } sct_op_t;

    typedef struct packed {
        sct_op_t          op;
        logic [RED_W-1:0] red_shift;
    } sct_cmd_t;

    typedef struct packed {
        logic term_gt_eps;
    } sct_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FOLD_PI,
        ST_FOLD_HALF,
        ST_SQUARE,
        ST_SEED,
        ST_LOOP,
        ST_REC,
        ST_DEN,
        ST_CORR,
        ST_FINISH
    } sct_state_t;

endpackage

FILE: hw/rtl/sct_dpath.sv
module sct_dpath
    import sct_pkg::*;
#(
    parameter int MAX_TERMS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  sct_cmd_t    cmd,
    input  logic        command,
    input  logic [31:0] angle,
    input  logic [30:0] tolerance,
    output sct_stat_t   stat,
    output logic [31:0] value
);

    localparam int M_W   = $clog2(2 * MAX_TERMS);
    localparam int DEN_W = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);

    // Denominators (m+1)(m+2) and their reciprocals floor(2^32 / den)
    logic [31:0]      recip_tab [2*MAX_TERMS];
    logic [DEN_W-1:0] den_tab   [2*MAX_TERMS];

    for (genvar gi = 0; gi < 2 * MAX_TERMS; gi++)
    begin : g_tab
        localparam int unsigned DEN_I = (gi + 1) * (gi + 2);
        localparam logic [32:0] REC_I = 33'h1_0000_0000 / DEN_I;
        assign recip_tab[gi] = REC_I[31:0];
        assign den_tab[gi]   = DEN_I[DEN_W-1:0];
    end

    logic               cos_reg;
    logic               use_cos_reg;
    logic               flip_reg;
    logic [X_W-1:0]     x_reg;
    logic [31:0]        x2_reg;
    logic [31:0]        term_reg;
    logic               term_neg_reg;
    logic signed [33:0] sum_reg;
    logic [M_W-1:0]     m_reg;
    logic [31:0]        p_reg;
    logic [31:0]        q0_reg;
    logic [63:0]        mul_reg;

    logic [31:0]    mag_in;
    logic [X_W-1:0] red_sub;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [31:0]    den32;
    logic [31:0]    rem;
    logic [31:0]    q;
    logic [33:0]    sum_mag;
    logic [33:0]    sat_mag;
    logic           res_neg;

    assign mag_in  = angle[31] ? (32'd0 - angle) : angle;
    assign red_sub = TWO_PI_X << cmd.red_shift;
    assign den32   = {{(32 - DEN_W){1'b0}}, den_tab[m_reg]};
    assign rem     = p_reg - mul_reg[31:0];
    assign q       = q0_reg + {31'd0, (rem >= den32)};

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = term_reg;
        mul_b = x2_reg;
        case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = x_reg[31:0];
                mul_b = x_reg[31:0];
            end
            OP_MUL_REC:
            begin
                mul_a = mul_reg[FRAC_BITS +: 32];
                mul_b = recip_tab[m_reg];
            end
            OP_MUL_DEN:
            begin
                mul_a = mul_reg[63:32];
                mul_b = den32;
            end
            default:
            begin
                mul_a = term_reg;
                mul_b = x2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // Step the working values under the controller's command
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cos_reg     <= command;
                use_cos_reg <= command;
                flip_reg    <= !command && angle[31];
                x_reg       <= {mag_in, {(X_W - 32){1'b0}}};
            end
            OP_REDUCE:
            begin
                if (x_reg >= red_sub)
                begin
                    x_reg <= x_reg - red_sub;
                end
            end
            OP_FOLD_PI:
            begin
                if (x_reg > PI_X)
                begin
                    x_reg    <= x_reg - PI_X;
                    flip_reg <= !flip_reg;
                end
            end
            OP_FOLD_HALF:
            begin
                if (x_reg > ONE_X)
                begin
                    use_cos_reg <= !cos_reg;
                    if (x_reg >= HALF_PI_X)
                    begin
                        x_reg <= x_reg - HALF_PI_X;
                        if (cos_reg)
                        begin
                            flip_reg <= !flip_reg;
                        end
                    end
                    else
                    begin
                        x_reg <= HALF_PI_X - x_reg;
                    end
                end
            end
            OP_SEED:
            begin
                x2_reg       <= mul_reg[FRAC_BITS +: 32];
                term_reg     <= use_cos_reg ? ONE_F[31:0] : x_reg[31:0];
                sum_reg      <= use_cos_reg ? $signed(ONE_F[33:0])
                                            : $signed({2'b00, x_reg[31:0]});
                term_neg_reg <= 1'b0;
                m_reg        <= use_cos_reg ? M_W'(0) : M_W'(1);
            end
            OP_MUL_REC:
            begin
                p_reg <= mul_reg[FRAC_BITS +: 32];
            end
            OP_MUL_DEN:
            begin
                q0_reg <= mul_reg[63:32];
            end
            OP_CORR:
            begin
                term_reg     <= q;
                term_neg_reg <= !term_neg_reg;
                if (!term_neg_reg)
                begin
                    sum_reg <= sum_reg - $signed({2'b00, q});
                end
                else
                begin
                    sum_reg <= sum_reg + $signed({2'b00, q});
                end
                m_reg <= m_reg + M_W'(2);
            end
            default:
            begin
            end
        endcase
    end

    assign stat.term_gt_eps = term_reg > {1'b0, tolerance};

    // Take the magnitude, saturate to one and apply the sign
    assign sum_mag = sum_reg[33] ? (34'd0 - sum_reg) : sum_reg;
    assign sat_mag = (sum_mag > SAT_ONE) ? SAT_ONE : sum_mag;
    assign res_neg = sum_reg[33] ^ flip_reg;
    assign value   = res_neg ? (32'd0 - sat_mag[31:0]) : sat_mag[31:0];

    // The reciprocal estimate is never more than one short
    a_corr_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CORR |-> {1'b0, rem} < {den32, 1'b0})
        else $error("quotient estimate off by more than one");

endmodule

FILE: hw/rtl/sct_ctrl.sv
module sct_ctrl
    import sct_pkg::*;
#(
    parameter int MAX_TERMS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    output logic      out_load,
    input  sct_stat_t stat,
    output sct_cmd_t  cmd
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    sct_state_t       state_reg;
    sct_state_t       state_next;
    logic [RED_W-1:0] red_cnt_reg;
    logic [RED_W-1:0] red_cnt_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            red_cnt_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            red_cnt_reg <= red_cnt_next;
            count_reg   <= count_next;
        end
    end

    // Accept a request, sequence reduction, folding and the series loop, then hand off the result
    always_comb
    begin
        state_next    = state_reg;
        red_cnt_next  = red_cnt_reg;
        count_next    = count_reg;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        cmd.op        = OP_IDLE;
        cmd.red_shift = red_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op       = OP_LOAD;
                    red_cnt_next = RED_W'(RED_STEPS - 1);
                    state_next   = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.op = OP_REDUCE;
                if (red_cnt_reg == '0)
                begin
                    state_next = ST_FOLD_PI;
                end
                else
                begin
                    red_cnt_next = red_cnt_reg - RED_W'(1);
                end
            end
            ST_FOLD_PI:
            begin
                cmd.op     = OP_FOLD_PI;
                state_next = ST_FOLD_HALF;
            end
            ST_FOLD_HALF:
            begin
                cmd.op     = OP_FOLD_HALF;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                cmd.op     = OP_SEED;
                count_next = CNT_W'(1);
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (stat.term_gt_eps && (count_reg < CNT_W'(MAX_TERMS)))
                begin
                    cmd.op     = OP_MUL_TERM;
                    state_next = ST_REC;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_REC:
            begin
                cmd.op     = OP_MUL_REC;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.op     = OP_MUL_DEN;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                cmd.op     = OP_CORR;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_LOOP;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_term_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond cap");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending one");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_REDUCE)
        else $error("accepted request did not start reduction");

    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOP && !stat.term_gt_eps |=> state_reg == ST_FINISH)
        else $error("series continued past tolerance");

endmodule

FILE: hw/rtl/sine_cosine_taylor_series_top.sv
// Channel   Dir  Signals                              Contents
// config    in   psel penable pwrite paddr pwdata     tolerance at byte address 0
//                prdata pready
// request   in   s_tvalid s_tready s_tdata s_tuser    angle Q7.24, command (0 sin, 1 cos)
// result    out  m_tvalid m_tready m_tdata            value Q2.30
//
// A new request is taken only once the last result is loaded into the output
// register. Shifted subtracts reduce the angle by two pi. Each further series
// term makes three passes through one shared 32x32 multiplier (term times x^2,
// times the reciprocal of the denominator, quotient back-check) and one step to
// correct the quotient and sum.
// rst_n clears the controller, the result valid and sets tolerance to 1024.
// A stalled result sits in the output register while the next request is
// already taken; the controller holds its finished result until that clears.
module sine_cosine_taylor_series_top
    import sct_pkg::*;
#(
    parameter int MAX_TERMS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    logic [30:0] tolerance_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    sct_cmd_t    cmd;
    sct_stat_t   stat;
    logic        out_free;
    logic        out_load;
    logic [31:0] value;

    // Configuration register write and readback
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= 31'd1024;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE))
        begin
            tolerance_reg <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOLERANCE) ? {1'b0, tolerance_reg} : 32'd0;

    sct_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    sct_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .command   (s_tuser[0]),
        .angle     (s_tdata),
        .tolerance (tolerance_reg),
        .stat      (stat),
        .value     (value)
    );

    // Hold the result until the sink takes it
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
